FILE: rtl/core/sqvt_pkg.sv
package sqvt_pkg;

    localparam int CordicStepsDef = 16;
    localparam int CordicMaxSteps = 24;
    localparam int TurnQ8    = 92160;
    localparam int HalfQ8    = 46080;
    localparam int QuarterQ8 = 23040;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] width;
        logic signed [23:0] height;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [23:0] angle_deg;
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
    } sqvt_in_t;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [23:0] vert_x;
        logic signed [23:0] vert_y;
        logic               last_corner;
    } sqvt_out_t;

    // Data carried along the cell chain
    typedef struct packed {
        logic               vld;
        logic               rot;
        logic               neg;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [39:0] w;
        logic signed [39:0] h;
        logic signed [23:0] center_x;
        logic signed [23:0] center_y;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [33:0] cz;
    } sqvt_cell_t;

    function automatic logic signed [31:0] atan_deg(input int i);
        logic signed [31:0] t [0:CordicMaxSteps-1];
        t = '{32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
              32'sd60000934, 32'sd30029717, 32'sd15018523, 32'sd7509720,
              32'sd3754917, 32'sd1877466, 32'sd938734, 32'sd469367,
              32'sd234684, 32'sd117342, 32'sd58671, 32'sd29335,
              32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
              32'sd917, 32'sd458, 32'sd229, 32'sd115};
        return t[i];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        if (v < -48'sd8388608) return -24'sd8388608;
        if (v > 48'sd8388607) return 24'sd8388607;
        return v[23:0];
    endfunction

endpackage

FILE: rtl/core/sqvt_cell.sv
module sqvt_cell import sqvt_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  sqvt_cell_t d_in,
    output sqvt_cell_t d_out
);

    sqvt_cell_t out_reg, out_next;

    always_comb begin
        out_next = d_in;
        if (d_in.cz >= 0) begin
            out_next.cx = d_in.cx - (d_in.cy >>> STEP);
            out_next.cy = d_in.cy + (d_in.cx >>> STEP);
            out_next.cz = d_in.cz - 34'(atan_deg(STEP));
        end else begin
            out_next.cx = d_in.cx + (d_in.cy >>> STEP);
            out_next.cy = d_in.cy - (d_in.cx >>> STEP);
            out_next.cz = d_in.cz + 34'(atan_deg(STEP));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.vld <= 1'b0;
        end else if (en) begin
            out_reg <= out_next;
        end
    end

    assign d_out = out_reg;

endmodule

FILE: rtl/core/sqvt_front.sv
module sqvt_front import sqvt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_vld,
    input  sqvt_in_t   in_data,
    output sqvt_cell_t d_out
);

    logic signed [23:0] r0, r1, r2;
    logic signed [39:0] pw, ph;
    logic               neg;
    sqvt_cell_t         out_reg, out_next;

    // Angle is within 24 bits, so mod 360 is at most ~91 turns: reduce via
    // reciprocal multiply with correction
    logic signed [47:0] qprod;
    logic signed [23:0] q;
    logic signed [47:0] rem;

    always_comb begin
        qprod = 48'(in_data.angle_deg) * 48'sd46603;
        q     = 24'(qprod >>> 32);
        rem   = 48'(in_data.angle_deg) - 48'(q) * 48'(TurnQ8);
        if (rem < 0) rem = rem + 48'(TurnQ8);
        if (rem >= 48'(TurnQ8)) rem = rem - 48'(TurnQ8);
        r0 = 24'(rem);
        r1 = (r0 > 24'(HalfQ8)) ? r0 - 24'(TurnQ8) : r0;
        neg = 1'b0;
        r2 = r1;
        if (r1 > 24'(QuarterQ8)) begin
            r2 = r1 - 24'(HalfQ8);
            neg = 1'b1;
        end else if (r1 < -24'(QuarterQ8)) begin
            r2 = r1 + 24'(HalfQ8);
            neg = 1'b1;
        end
        pw = 40'(in_data.width) * 40'(in_data.scale_x) + 40'sd128;
        ph = 40'(in_data.height) * 40'(in_data.scale_y) + 40'sd128;
        out_next.vld      = in_vld;
        out_next.rot      = in_data.angle_deg != '0;
        out_next.neg      = neg;
        out_next.pos_x    = in_data.pos_x;
        out_next.pos_y    = in_data.pos_y;
        out_next.w        = pw >>> 8;
        out_next.h        = ph >>> 8;
        out_next.center_x = in_data.center_x;
        out_next.center_y = in_data.center_y;
        out_next.cx       = CordicGain;
        out_next.cy       = '0;
        out_next.cz       = 34'(r2) <<< 16;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.vld <= 1'b0;
        end else if (en) begin
            out_reg <= out_next;
        end
    end

    assign d_out = out_reg;

endmodule

FILE: rtl/core/sqvt_emit.sv
module sqvt_emit import sqvt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  sqvt_cell_t d_in,
    output logic       busy,
    input  logic       m_ready,
    output logic       m_valid,
    output sqvt_out_t  m_data
);

    // Stage A: trig rounding; stage B: products; output: combinational sums from stage B
    logic               a_vld_reg;
    logic               a_rot_reg;
    logic signed [23:0] a_px_reg, a_py_reg, a_cxo_reg, a_cyo_reg;
    logic signed [39:0] a_w_reg, a_h_reg;
    logic signed [19:0] a_cs_reg, a_sn_reg;
    logic signed [19:0] cs_next, sn_next;
    logic signed [33:0] rx, ry;

    logic               b_full_reg;
    logic signed [47:0] ox_reg, oy_reg, xx_reg, xy_reg, yx_reg, yy_reg;
    logic signed [47:0] ox_next, oy_next, xx_next, xy_next, yx_next, yy_next;
    logic [1:0]         cnt_reg;

    logic               take_a, take_b;

    function automatic logic signed [47:0] mt(input logic signed [39:0] a,
                                              input logic signed [19:0] t);
        logic signed [63:0] p;
        p = 64'(a) * 64'(t) + 64'sd32768;
        return 48'(p >>> 16);
    endfunction

    assign busy   = a_vld_reg && b_full_reg && !take_b;
    assign take_b = b_full_reg && m_ready && cnt_reg == 2'd3;
    assign take_a = a_vld_reg && (!b_full_reg || take_b);

    always_comb begin
        rx = (d_in.cx + 34'sd8192) >>> 14;
        ry = (d_in.cy + 34'sd8192) >>> 14;
        cs_next = d_in.neg ? -20'(rx) : 20'(rx);
        sn_next = d_in.neg ? -20'(ry) : 20'(ry);
        if (a_rot_reg) begin
            ox_next = 48'(a_px_reg) - mt(40'(a_cxo_reg), a_cs_reg)
                      - mt(40'(a_cyo_reg), a_sn_reg);
            oy_next = 48'(a_py_reg) + mt(40'(a_cxo_reg), a_sn_reg)
                      - mt(40'(a_cyo_reg), a_cs_reg);
            xx_next = mt(a_w_reg, a_cs_reg);
            xy_next = -mt(a_w_reg, a_sn_reg);
            yx_next = mt(a_h_reg, a_sn_reg);
            yy_next = mt(a_h_reg, a_cs_reg);
        end else begin
            ox_next = 48'(a_px_reg);
            oy_next = 48'(a_py_reg);
            xx_next = 48'(a_w_reg);
            xy_next = '0;
            yx_next = '0;
            yy_next = 48'(a_h_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg  <= 1'b0;
            b_full_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (!busy) begin
                a_vld_reg <= d_in.vld;
                a_rot_reg <= d_in.rot;
                a_px_reg  <= d_in.pos_x;
                a_py_reg  <= d_in.pos_y;
                a_cxo_reg <= d_in.center_x;
                a_cyo_reg <= d_in.center_y;
                a_w_reg   <= d_in.w;
                a_h_reg   <= d_in.h;
                a_cs_reg  <= cs_next;
                a_sn_reg  <= sn_next;
            end
            if (b_full_reg && m_ready) cnt_reg <= cnt_reg + 2'd1;
            if (take_a) begin
                b_full_reg <= 1'b1;
                ox_reg <= ox_next; oy_reg <= oy_next;
                xx_reg <= xx_next; xy_reg <= xy_next;
                yx_reg <= yx_next; yy_reg <= yy_next;
            end else if (take_b) begin
                b_full_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        m_valid            = b_full_reg;
        m_data.corner      = cnt_reg;
        m_data.last_corner = cnt_reg == 2'd3;
        unique case (cnt_reg)
            2'd0: begin
                m_data.vert_x = sat24(ox_reg);
                m_data.vert_y = sat24(oy_reg);
            end
            2'd1: begin
                m_data.vert_x = sat24(ox_reg + xx_reg);
                m_data.vert_y = sat24(oy_reg + xy_reg);
            end
            2'd2: begin
                m_data.vert_x = sat24(ox_reg + xx_reg + yx_reg);
                m_data.vert_y = sat24(oy_reg + xy_reg + yy_reg);
            end
            default: begin
                m_data.vert_x = sat24(ox_reg + yx_reg);
                m_data.vert_y = sat24(oy_reg + yy_reg);
            end
        endcase
    end

endmodule

FILE: rtl/core/sprite_quad_vertex_transform.sv
// Path: front register, CORDIC cells, emit stages A and B, then the combinational output.
// Each sprite leaves as four corner transactions; the input stalls while the output side is full.
// The CORDIC is a chain of CORDIC_STEPS cells, one rotation per cell.
// Reset: aresetn synchronous, active low; clears all valid flags.
module sprite_quad_vertex_transform import sqvt_pkg::*; #(
    parameter int CORDIC_STEPS = CordicStepsDef
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sqvt_in_t  s_data,
    input  logic      m_ready,
    output logic      m_valid,
    output sqvt_out_t m_data
);

    sqvt_cell_t chain [0:CORDIC_STEPS];
    logic       busy;

    // Stall whole chain while the output side is full
    assign s_ready = !busy;

    sqvt_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(!busy),
        .in_vld(s_valid), .in_data(s_data), .d_out(chain[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        sqvt_cell #(.STEP(i)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(!busy),
            .d_in(chain[i]), .d_out(chain[i+1])
        );
    end

    sqvt_emit u_emit (
        .aclk(aclk), .aresetn(aresetn), .d_in(chain[CORDIC_STEPS]),
        .busy(busy), .m_ready(m_ready), .m_valid(m_valid), .m_data(m_data)
    );

endmodule

FILE: tb/sv/sprite_quad_vertex_transform_tb.sv
module sprite_quad_vertex_transform_tb import sqvt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Steps = CordicStepsDef;
    localparam int WatchLimit = 20000;

    localparam longint AtanTab [0:23] = '{
        754974720, 445687602, 235489088, 119537938,
        60000934, 30029717, 15018523, 7509720,
        3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335,
        14668, 7334, 3667, 1833,
        917, 458, 229, 115};

    class corner_board;
        sqvt_out_t corners_due[$];
        int        n_bad;

        function longint round_q(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function sqvt_out_t corner_of(int k, longint vx, longint vy);
            sqvt_out_t c;
            c.corner      = k[1:0];
            c.vert_x      = (vx < -8388608) ? -24'sd8388608 :
                            (vx > 8388607) ? 24'sd8388607 : vx[23:0];
            c.vert_y      = (vy < -8388608) ? -24'sd8388608 :
                            (vy > 8388607) ? 24'sd8388607 : vy[23:0];
            c.last_corner = (k == 3);
            return c;
        endfunction

        function void note_sprite(sqvt_in_t d);
            longint px, py, w, h, r, x, y, z, dx, dy, cs, sn, ox, oy, xx, xy, yx, yy;
            bit neg;
            px = d.pos_x;
            py = d.pos_y;
            w  = round_q(longint'(d.width) * longint'(d.scale_x), 8);
            h  = round_q(longint'(d.height) * longint'(d.scale_y), 8);
            if (d.angle_deg == 0) begin
                corners_due.push_back(corner_of(0, px, py));
                corners_due.push_back(corner_of(1, px + w, py));
                corners_due.push_back(corner_of(2, px + w, py + h));
                corners_due.push_back(corner_of(3, px, py + h));
                return;
            end
            r = longint'(d.angle_deg) % TurnQ8;
            neg = 0;
            if (r < 0) r += TurnQ8;
            if (r > HalfQ8) r -= TurnQ8;
            if (r > QuarterQ8) begin
                r -= HalfQ8;
                neg = 1;
            end else if (r < -QuarterQ8) begin
                r += HalfQ8;
                neg = 1;
            end
            z = r * 65536;
            x = CordicGain;
            y = 0;
            for (int i = 0; i < Steps && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= AtanTab[i];
                end else begin
                    x += dx; y -= dy; z += AtanTab[i];
                end
            end
            cs = round_q(x, 14);
            sn = round_q(y, 14);
            if (neg) begin
                cs = -cs;
                sn = -sn;
            end
            ox = px - round_q(longint'(d.center_x) * cs, 16)
                    - round_q(longint'(d.center_y) * sn, 16);
            oy = py + round_q(longint'(d.center_x) * sn, 16)
                    - round_q(longint'(d.center_y) * cs, 16);
            xx = round_q(w * cs, 16);
            xy = -round_q(w * sn, 16);
            yx = round_q(h * sn, 16);
            yy = round_q(h * cs, 16);
            corners_due.push_back(corner_of(0, ox, oy));
            corners_due.push_back(corner_of(1, ox + xx, oy + xy));
            corners_due.push_back(corner_of(2, ox + xx + yx, oy + xy + yy));
            corners_due.push_back(corner_of(3, ox + yx, oy + yy));
        endfunction

        function void check_corner(sqvt_out_t got);
            sqvt_out_t want;
            if (corners_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected corner %p", got);
                return;
            end
            want = corners_due.pop_front();
            if (got !== want) begin
                n_bad++;
                if (n_bad <= 10) $display("corner mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    sqvt_in_t  s_data;
    logic      m_ready;
    logic      m_valid;
    sqvt_out_t m_data;

    corner_board board;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles;

    sprite_quad_vertex_transform i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_ready(m_ready), .m_valid(m_valid), .m_data(m_data)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_sprite(s_data);
            if (m_valid && m_ready) board.check_corner(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WatchLimit) begin
                $display("*** FAILED ***");
                $finish;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [23:0] rand_q24();
        case ($urandom_range(5))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return 24'(($urandom_range(8191) - 4096));
            3: return 24'(($urandom_range(65535) - 32768) * 16);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_q16();
        case ($urandom_range(4))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(($urandom_range(1023) - 512));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [23:0] rand_angle();
        case ($urandom_range(6))
            0: return 24'sd0;
            1: return 24'($urandom_range(16) * 23040 - 184320);
            2: return 24'(($urandom_range(184320) - 92160));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_sprite(input sqvt_in_t d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_corners();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.corners_due.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random(input int n);
        sqvt_in_t d;
        for (int i = 0; i < n; i++) begin
            d.pos_x = rand_q24();     d.pos_y = rand_q24();
            d.width = rand_q24();     d.height = rand_q24();
            d.scale_x = rand_q16();   d.scale_y = rand_q16();
            d.angle_deg = rand_angle();
            d.center_x = rand_q24();  d.center_y = rand_q24();
            send_sprite(d);
        end
    endtask

    task automatic send_directed();
        sqvt_in_t d;
        logic signed [23:0] angs [0:11];
        angs = '{24'sd0, 24'sd256, -24'sd256, 24'sd23040, -24'sd23040, 24'sd46080,
                 -24'sd46080, 24'sd92160, -24'sd92160, 24'sd69120, 24'sh7fffff,
                 24'sh800000};
        for (int i = 0; i < 12; i++) begin
            d = '{24'sd2560, -24'sd2560, 24'sd4096, 24'sd2048, 16'sd256, 16'sd512,
                  angs[i], 24'sd1024, -24'sd512};
            d.angle_deg = angs[i];
            d.center_x = 24'sd1024;
            d.center_y = -24'sd512;
            send_sprite(d);
        end
        d = '{24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh800000, 16'sh7fff, 16'sh8000,
              24'sd0, 24'sh7fffff, 24'sh800000};
        send_sprite(d);
        d.angle_deg = 24'sd11520;
        send_sprite(d);
        d = '{24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 16'sh8000, 16'sh7fff,
              -24'sd11520, 24'sh800000, 24'sh7fffff};
        send_sprite(d);
        d = '{24'sd0, 24'sd0, -24'sd4096, 24'sd4096, -16'sd256, 16'sd256,
              24'sd7680, 24'sd0, 24'sd0};
        send_sprite(d);
        d = '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 24'sd1, 24'sd0, 24'sd0};
        send_sprite(d);
        d = '{24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 16'hffff, 16'hffff,
              24'hffffff, 24'hffffff, 24'hffffff};
        send_sprite(d);
    endtask

    initial begin
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 26;
        recv_idle_pct = 88;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_directed();
        send_random(130);
        drain_corners();
        send_idle_pct = 88;
        recv_idle_pct = 26;
        send_random(150);
        drain_corners();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(170);
        drain_corners();
        repeat (Steps + 20) @(posedge aclk);
        if (board.n_bad == 0 && board.corners_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
